// ===== design/lant_pkg.sv =====
// Shared types, codes and constants for the Langton's ant stepper.
`default_nettype none

package lant_pkg;

    // Sizes of the fixed stream and configuration fields.
    localparam int OP_W       = 2;
    localparam int COORD_W    = 9;
    localparam int HEAD_W     = 2;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Default grid storage size.
    localparam int MAX_ROWS_DEF = 512;
    localparam int MAX_COLS_DEF = 512;

    // Size registers come out of reset at this value.
    localparam logic [CFG_W-1:0] GRID_RESET = 10'd500;

    // Operation codes carried in tuser.
    localparam logic [OP_W-1:0] OP_STEP    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // Headings.
    localparam logic [HEAD_W-1:0] HEAD_UP = 2'd0;

    // Row and column movement for each heading: up, left, down, right.
    typedef logic signed [1:0] delta_t;
    localparam delta_t MOVE_DR [4] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};
    localparam delta_t MOVE_DC [4] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the accepted input beat and start the row read
        logic commit;    // finish the item: load the result, update ant and grid
        logic clear_wr;  // write one zero row of the clearing pass
    } lant_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_free;
        logic            clr_last;
    } lant_sts_t;

endpackage

`default_nettype wire

// ===== design/lant_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lant_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lant_ctrl.sv =====
// Controller: sequences the clearing pass and the accept and commit steps of each item.
`default_nettype none

module lant_ctrl
    import lant_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire lant_sts_t sts,
    output lant_cmd_t      cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.latch    = 1'b0;
        cmd.commit   = 1'b0;
        cmd.clear_wr = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result waits here until the output register can take it.
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = (sts.op == OP_RESTART) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/lant_dpath.sv =====
// Datapath: size registers, ant state, grid memory and the output register.
`default_nettype none

module lant_dpath
    import lant_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lant_cmd_t            cmd,
    output lant_sts_t                 sts,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [OP_W-1:0]      in_op,
    input  wire logic [COORD_W-1:0]   in_row,
    input  wire logic [COORD_W-1:0]   in_col,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      out_cell,
    output logic [COORD_W-1:0]        out_row,
    output logic [COORD_W-1:0]        out_col,
    output logic [HEAD_W-1:0]         out_head
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int DIM_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int WIDE_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int CALC_W = ((WIDE_W > COORD_W) ? WIDE_W : COORD_W) + 1;
    localparam int RST_ROW = ((int'(GRID_RESET) > MAX_ROWS) ? MAX_ROWS : int'(GRID_RESET)) / 2;
    localparam int RST_COL = ((int'(GRID_RESET) > MAX_COLS) ? MAX_COLS : int'(GRID_RESET)) / 2;

    logic [CFG_W-1:0]   grid_width_reg;
    logic [CFG_W-1:0]   grid_height_reg;
    logic [ROW_W-1:0]   pos_row_reg;
    logic [COL_W-1:0]   pos_col_reg;
    logic [HEAD_W-1:0]  heading_reg;
    logic [OP_W-1:0]    op_reg;
    logic [ROW_W-1:0]   r_sat_reg;
    logic [COL_W-1:0]   c_sat_reg;
    logic [CALC_W-1:0]  rr_reg;
    logic [CALC_W-1:0]  rc_reg;
    logic [ROW_W-1:0]   clr_cnt_reg;
    logic               out_valid_reg;

    logic [CALC_W-1:0]  h_bound;
    logic [CALC_W-1:0]  w_bound;
    logic [CALC_W-1:0]  row_ext;
    logic [CALC_W-1:0]  col_ext;
    logic [CALC_W-1:0]  row_sat;
    logic [CALC_W-1:0]  col_sat;
    logic [CALC_W-1:0]  rd_row_ext;
    logic [CALC_W-1:0]  r_ext;
    logic [CALC_W-1:0]  c_ext;
    logic [CALC_W-1:0]  step_row;
    logic [CALC_W-1:0]  step_col;
    logic [CALC_W-1:0]  row_next;
    logic [CALC_W-1:0]  col_next;
    logic [HEAD_W-1:0]  head_next;
    logic [HEAD_W-1:0]  turn_head;
    logic               cell_next;
    logic               old_bit;
    delta_t             dr;
    delta_t             dc;

    logic               ram_we;
    logic [ROW_W-1:0]   ram_waddr;
    logic [MAX_COLS-1:0] ram_wdata;
    logic [ROW_W-1:0]   ram_raddr;
    logic [MAX_COLS-1:0] ram_rdata;

    // Effective bounds: the size register saturated into 1..MAX.
    always_comb
    begin
        if (grid_height_reg == '0)
        begin
            h_bound = CALC_W'(1);
        end
        else if (CALC_W'(grid_height_reg) > CALC_W'(MAX_ROWS))
        begin
            h_bound = CALC_W'(MAX_ROWS);
        end
        else
        begin
            h_bound = CALC_W'(grid_height_reg);
        end
        if (grid_width_reg == '0)
        begin
            w_bound = CALC_W'(1);
        end
        else if (CALC_W'(grid_width_reg) > CALC_W'(MAX_COLS))
        begin
            w_bound = CALC_W'(MAX_COLS);
        end
        else
        begin
            w_bound = CALC_W'(grid_width_reg);
        end
    end

    // An ant left outside a shrunk grid is pulled back to the last row or column.
    assign row_ext    = CALC_W'(pos_row_reg);
    assign col_ext    = CALC_W'(pos_col_reg);
    assign row_sat    = (row_ext < h_bound) ? row_ext : h_bound - CALC_W'(1);
    assign col_sat    = (col_ext < w_bound) ? col_ext : w_bound - CALC_W'(1);
    assign rd_row_ext = CALC_W'(in_row);
    assign ram_raddr  = (in_op == OP_STEP) ? row_sat[ROW_W-1:0] : rd_row_ext[ROW_W-1:0];

    // Step arithmetic on the fetched row.
    assign r_ext     = CALC_W'(r_sat_reg);
    assign c_ext     = CALC_W'(c_sat_reg);
    assign old_bit   = ram_rdata[c_sat_reg];
    assign turn_head = old_bit ? heading_reg + 2'd1 : heading_reg - 2'd1;
    assign dr        = MOVE_DR[turn_head];
    assign dc        = MOVE_DC[turn_head];

    always_comb
    begin
        if (dr == 2'sd1)
        begin
            step_row = (r_ext == h_bound - CALC_W'(1)) ? '0 : r_ext + CALC_W'(1);
        end
        else if (dr == -2'sd1)
        begin
            step_row = (r_ext == '0) ? h_bound - CALC_W'(1) : r_ext - CALC_W'(1);
        end
        else
        begin
            step_row = r_ext;
        end
        if (dc == 2'sd1)
        begin
            step_col = (c_ext == w_bound - CALC_W'(1)) ? '0 : c_ext + CALC_W'(1);
        end
        else if (dc == -2'sd1)
        begin
            step_col = (c_ext == '0) ? w_bound - CALC_W'(1) : c_ext - CALC_W'(1);
        end
        else
        begin
            step_col = c_ext;
        end
    end

    always_comb
    begin
        row_next  = row_ext;
        col_next  = col_ext;
        head_next = heading_reg;
        cell_next = 1'b0;
        unique case (op_reg)
            OP_STEP:
            begin
                row_next  = step_row;
                col_next  = step_col;
                head_next = turn_head;
                cell_next = ~old_bit;
            end
            OP_READ:
            begin
                if ((rr_reg < h_bound) && (rc_reg < w_bound))
                begin
                    cell_next = ram_rdata[rc_reg[COL_W-1:0]];
                end
            end
            OP_RESTART:
            begin
                row_next  = h_bound >> 1;
                col_next  = w_bound >> 1;
                head_next = HEAD_UP;
            end
            default:
            begin
                cell_next = 1'b0;
            end
        endcase
    end

    // Grid writes: zero rows during clearing, the flipped row on a step.
    assign ram_we    = cmd.clear_wr || (cmd.commit && (op_reg == OP_STEP));
    assign ram_waddr = cmd.clear_wr ? clr_cnt_reg : r_sat_reg;
    assign ram_wdata = cmd.clear_wr ? '0
                                    : ram_rdata ^ (MAX_COLS'(1) << c_sat_reg);

    lant_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.latch),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_RESET;
            grid_height_reg <= GRID_RESET;
            pos_row_reg     <= ROW_W'(RST_ROW);
            pos_col_reg     <= COL_W'(RST_COL);
            heading_reg     <= HEAD_UP;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_GRID_WIDTH)
                begin
                    grid_width_reg <= cfg_data;
                end
                else
                begin
                    grid_height_reg <= cfg_data;
                end
            end
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + ROW_W'(1);
            end
            if (cmd.commit)
            begin
                pos_row_reg <= row_next[ROW_W-1:0];
                pos_col_reg <= col_next[COL_W-1:0];
                heading_reg <= head_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= in_op;
            rr_reg    <= CALC_W'(in_row);
            rc_reg    <= CALC_W'(in_col);
            r_sat_reg <= row_sat[ROW_W-1:0];
            c_sat_reg <= col_sat[COL_W-1:0];
        end
        if (cmd.commit)
        begin
            out_cell <= cell_next;
            out_row  <= row_next[COORD_W-1:0];
            out_col  <= col_next[COORD_W-1:0];
            out_head <= head_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.op       = op_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.clr_last = (clr_cnt_reg == ROW_W'(MAX_ROWS - 1));

endmodule

`default_nettype wire

// ===== design/langton_ant_stepper.sv =====
// Each item reads its grid row on the accepting beat and completes from the execute
// state when its result enters the output register, waiting while that register is full.
// The single read then write of the row-wide grid memory means a new item is taken only
// once the last completes, but the output register lets an item in while a result waits.
// Reset and each restart run a clearing pass over all MAX_ROWS rows, one grid row per cycle,
// during which no item is accepted; configuration writes are taken at any time.
`default_nettype none

module langton_ant_stepper
    import lant_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // read_row[8:0], read_col[17:9]
    input  wire logic [OP_W-1:0]       s_axis_tuser,  // operation[1:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // cell_value[0], ant_row[9:1],
                                                      // ant_col[18:10], ant_heading[20:19]
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    lant_cmd_t           cmd;
    lant_sts_t           sts;
    logic                out_cell;
    logic [COORD_W-1:0]  out_row;
    logic [COORD_W-1:0]  out_col;
    logic [HEAD_W-1:0]   out_head;

    assign cfg_ready = 1'b1;

    lant_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lant_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tuser),
        .in_row    (s_axis_tdata[COORD_W-1:0]),
        .in_col    (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_cell  (out_cell),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_head  (out_head)
    );

    assign m_axis_tdata = {3'b000, out_head, out_col, out_row, out_cell};

    // One item at a time: an accepted beat is never followed by another at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on the cycle after an accepted beat");

    // The clearing pass never overlaps accepting an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !s_axis_tready)
        else $error("input ready during the clearing pass");

    // A result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a beat still waiting at the output");

    // A commit always follows an accepted beat and never comes on its own cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> !cmd.commit)
        else $error("commit on the accepting cycle");

endmodule

`default_nettype wire

// ===== tb/langton_ant_checker.sv =====
// Checker for the Langton's ant stepper: predicts each result and compares it.
module langton_ant_checker
    import lant_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // read_row[8:0], read_col[17:9]
    input  wire logic [OP_W-1:0]       s_axis_tuser,   // operation[1:0]
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,   // cell_value[0], ant_row[9:1],
                                                       // ant_col[18:10], ant_heading[20:19]
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    output int                         failures,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd3;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               cell_val;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [HEAD_W-1:0]  heading;
    } ant_report_t;

    bit   [MAX_COLS_DEF-1:0] cells [MAX_ROWS_DEF];
    logic [CFG_W-1:0]        width_reg  = GRID_RESET;
    logic [CFG_W-1:0]        height_reg = GRID_RESET;
    int                      ant_row;
    int                      ant_col;
    logic [HEAD_W-1:0]       ant_heading;
    ant_report_t             awaited_reports [$];

    // Size registers are saturated into 1..limit before they are used as wrap bounds.
    function automatic int usable_bound(input logic [CFG_W-1:0] value, input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic void clear_and_centre();
        foreach (cells[i])
            cells[i] = '0;
        ant_row     = usable_bound(height_reg, MAX_ROWS_DEF) / 2;
        ant_col     = usable_bound(width_reg, MAX_COLS_DEF) / 2;
        ant_heading = HEAD_UP;
    endfunction

    function automatic ant_report_t apply_ant_item(input logic [OP_W-1:0] op,
                                                   input logic [COORD_W-1:0] rd_row,
                                                   input logic [COORD_W-1:0] rd_col);
        int          h;
        int          w;
        int          r;
        int          c;
        int          dr;
        int          dc;
        logic        prev;
        ant_report_t rep;
        h = usable_bound(height_reg, MAX_ROWS_DEF);
        w = usable_bound(width_reg, MAX_COLS_DEF);
        rep.cell_val = 1'b0;
        case (op)
            OP_STEP:
            begin
                // An ant left outside a shrunk grid is pulled back onto its last row
                // or column.
                r = (ant_row < h) ? ant_row : h - 1;
                c = (ant_col < w) ? ant_col : w - 1;
                prev = cells[r][c];
                cells[r][c] = ~prev;
                rep.cell_val = ~prev;
                ant_heading = prev ? ant_heading + 1'b1 : ant_heading - 1'b1;
                dr = 0;
                dc = 0;
                case (ant_heading)
                    HEAD_UP:    dr = -1;
                    HEAD_LEFT:  dc = -1;
                    HEAD_DOWN:  dr = 1;
                    HEAD_RIGHT: dc = 1;
                    default:    dc = 0;
                endcase
                ant_row = (r + dr + h) % h;
                ant_col = (c + dc + w) % w;
            end
            OP_READ:
            begin
                if (rd_row < h && rd_col < w)
                    rep.cell_val = cells[rd_row][rd_col];
            end
            OP_RESTART:
                clear_and_centre();
            default:
                rep.cell_val = 1'b0;
        endcase
        rep.row     = COORD_W'(ant_row);
        rep.col     = COORD_W'(ant_col);
        rep.heading = ant_heading;
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ant_report_t got;
        ant_report_t want;
        if (!rst_n)
        begin
            width_reg  = GRID_RESET;
            height_reg = GRID_RESET;
            clear_and_centre();
            awaited_reports.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  width_reg  = cfg_data;
                    CFG_GRID_HEIGHT: height_reg = cfg_data;
                    default:         width_reg  = width_reg;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.cell_val = m_axis_tdata[0];
                got.row      = m_axis_tdata[9:1];
                got.col      = m_axis_tdata[18:10];
                got.heading  = m_axis_tdata[20:19];
                if (awaited_reports.size() == 0)
                begin
                    if (failures < REPORT_LIMIT)
                        $display({"%0t: result beat with nothing awaited: ",
                                  "cell %0d row %0d col %0d heading %0d"},
                                 $realtime, got.cell_val, got.row, got.col, got.heading);
                    failures++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got != want)
                    begin
                        if (failures < REPORT_LIMIT)
                            $display({"%0t: mismatch (expected/actual) cell %0d/%0d ",
                                      "row %0d/%0d col %0d/%0d heading %0d/%0d"},
                                     $realtime, want.cell_val, got.cell_val,
                                     want.row, got.row, want.col, got.col,
                                     want.heading, got.heading);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_reports.push_back(apply_ant_item(s_axis_tuser, s_axis_tdata[8:0],
                                                         s_axis_tdata[17:9]));
            outstanding = awaited_reports.size();
        end
    end

endmodule

// ===== tb/tb_langton_ant_stepper.sv =====
// Testbench top for the Langton's ant stepper: clock, reset, stimulus and verdict.
module tb_langton_ant_stepper
    import lant_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 64;
    localparam int PHASES       = 10;
    localparam logic [CFG_W-1:0] PHASE_W [PHASES] = '{1, 512, 2, 1023, 16, 8, 0, 31, 5, 700};
    localparam logic [CFG_W-1:0] PHASE_H [PHASES] = '{1, 512, 2, 0, 16, 3, 1023, 17, 7, 300};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // read_row[8:0], read_col[17:9]
    logic [OP_W-1:0]       s_axis_tuser;   // operation[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // cell_value[0], ant_row[9:1],
                                           // ant_col[18:10], ant_heading[20:19]
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int failures;
    int outstanding;
    int cycle_count = 0;
    bit steady;
    int hold_requests;
    int holds_done;
    int cur_w;
    int cur_h;

    langton_ant_stepper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    langton_ant_checker ant_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL langton_ant_stepper");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold whenever one is requested.
    initial
    begin
        m_axis_tready = 1'b0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= 32);
        end
    end

    task automatic offer_item(input logic [OP_W-1:0] op, input int unsigned row,
                              input int unsigned col);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'({col[COORD_W-1:0], row[COORD_W-1:0]});
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic drain();
        pause_sender(1);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sizes change only once the block is idle, including any clearing pass after a restart.
    task automatic resize(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        drain();
        repeat (MAX_ROWS_DEF + 8) @(negedge clk);
        write_size(CFG_GRID_WIDTH, w);
        write_size(CFG_GRID_HEIGHT, h);
        cur_w = (w == 0) ? 1 : ((w > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(w));
        cur_h = (h == 0) ? 1 : ((h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(h));
    endtask

    // Mostly steps so the pattern grows, reads mostly inside the grid, a little noise.
    task automatic random_item();
        int unsigned pick;
        pick = $urandom_range(99);
        if (!steady && $urandom_range(99) < 32)
            pause_sender($urandom_range(1, 4));
        if (pick < 68)
            offer_item(OP_STEP, $urandom, $urandom);
        else if (pick < 88)
            offer_item(OP_READ, $urandom_range(cur_h - 1), $urandom_range(cur_w - 1));
        else if (pick < 94)
            offer_item(OP_READ, $urandom_range(511), $urandom_range(511));
        else if (pick < 97)
            offer_item(OP_UNUSED, $urandom, $urandom);
        else
            offer_item(OP_RESTART, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_STEP;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_GRID_WIDTH;
        cfg_data      = '0;
        steady        = 1'b0;
        hold_requests = 0;
        cur_w         = GRID_RESET;
        cur_h         = GRID_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Out of reset the ant sits at the centre of a 500 by 500 grid.
        offer_item(OP_READ, 250, 250);
        offer_item(OP_STEP, 0, 0);
        offer_item(OP_STEP, 511, 511);
        offer_item(OP_READ, 250, 250);
        offer_item(OP_READ, 511, 511);
        offer_item(OP_READ, 499, 499);
        offer_item(OP_UNUSED, 511, 511);
        repeat (5) offer_item(OP_STEP, 0, 0);

        // Width saturates to one column and height to the storage limit; the ant is outside.
        resize(0, 1023);
        offer_item(OP_READ, 0, 0);
        offer_item(OP_STEP, 0, 0);
        offer_item(OP_STEP, 0, 0);
        offer_item(OP_READ, 511, 0);
        offer_item(OP_READ, 250, 1);

        resize(1023, 0);
        offer_item(OP_UNUSED, 0, 0);
        offer_item(OP_STEP, 0, 0);
        offer_item(OP_STEP, 0, 0);

        resize(3, 2);
        repeat (3) offer_item(OP_STEP, 0, 0);
        offer_item(OP_RESTART, 0, 0);

        // Cells set earlier beyond the small grid must have been cleared by the restart.
        resize(512, 512);
        offer_item(OP_READ, 250, 250);
        offer_item(OP_READ, 511, 511);

        for (int p = 0; p < PHASES + 2; p++)
        begin
            if (p < PHASES)
                resize(PHASE_W[p], PHASE_H[p]);
            else
                resize(CFG_W'($urandom), CFG_W'($urandom));
            if ($urandom_range(1) == 1)
                offer_item(OP_RESTART, $urandom, $urandom);
            steady <= (p == 4);
            if (p == 2)
                hold_requests <= hold_requests + 1;
            repeat (PHASE_ITEMS) random_item();
        end

        drain();
        repeat (20) @(negedge clk);
        if (failures == 0 && outstanding == 0)
            $display("PASS langton_ant_stepper");
        else
            $display("FAIL langton_ant_stepper");
        $finish;
    end

endmodule
